/* rtl/frame_to_cartesian_converter_macros.svh */
// ----------------------------------------------------------------------------
// Frame to Cartesian converter assertion macros
// Shared concurrent check templates used by the converter top level.
// ----------------------------------------------------------------------------
`ifndef FRAME_TO_CARTESIAN_CONVERTER_MACROS_SVH
`define FRAME_TO_CARTESIAN_CONVERTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define F2C_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define F2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/f2c_pkg.sv */
// ----------------------------------------------------------------------------
// Frame to Cartesian converter package
// Fixed trig formats, CORDIC constants and shared code types.
// ----------------------------------------------------------------------------
package f2c_pkg;

    // angle as a full-turn fraction, quadrant in the top two bits
    localparam int TURN_W       = 32;
    // sine / cosine are Q2.30, held with headroom
    localparam int TRIG_W       = 34;
    localparam int TRIG_FRAC    = 30;
    // pipeline depth of the scaled multiplier
    localparam int MUL_LAT      = 4;
    localparam int ATAN_ENTRIES = 24;

    // reciprocal of the limiting CORDIC gain, 0.60725293500888 in Q2.30
    localparam logic signed [TRIG_W-1:0] CORDIC_START = TRIG_W'(652032874);

    // atan(2^-i) as a fraction of a full turn
    localparam logic [TURN_W-1:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        KIND_CART    = 2'd0,
        KIND_CYL     = 2'd1,
        KIND_SPH     = 2'd2,
        KIND_INVALID = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quadrant;

endpackage

/* rtl/f2c_if.sv */
// ----------------------------------------------------------------------------
// Frame to Cartesian converter stream interfaces
// Valid/ready channels for input points and Cartesian result words.
// ----------------------------------------------------------------------------

// input point channel
interface f2c_pt_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    f2c_pkg::t_kind               kind;
    logic signed [DATA_WIDTH-1:0] coord_a;
    logic signed [DATA_WIDTH-1:0] coord_b;
    logic signed [DATA_WIDTH-1:0] coord_c;

    modport source (output valid, kind, coord_a, coord_b, coord_c, input ready);
    modport sink   (input valid, kind, coord_a, coord_b, coord_c, output ready);
endinterface

// Cartesian result channel
interface f2c_xyz_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_out;
    logic signed [DATA_WIDTH-1:0] y_out;
    logic signed [DATA_WIDTH-1:0] z_out;

    modport source (output valid, x_out, y_out, z_out, input ready);
    modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

/* rtl/f2c_cordic.sv */
// ----------------------------------------------------------------------------
// Pipelined rotation-mode CORDIC
// One register stage per micro-rotation; gives cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module f2c_cordic #(
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [ANGLE_WIDTH-1:0]            i_angle,
    output logic signed [f2c_pkg::TRIG_W-1:0] o_cos,
    output logic signed [f2c_pkg::TRIG_W-1:0] o_sin
);
    import f2c_pkg::*;

    logic signed [TRIG_W-1:0] r_x [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] r_y [0:CORDIC_STAGES];
    logic signed [TRIG_W-1:0] r_z [0:CORDIC_STAGES];
    logic [1:0]               r_q [0:CORDIC_STAGES];
    logic [TURN_W-1:0]        w_turn;
    logic signed [TRIG_W-1:0] n_cos;
    logic signed [TRIG_W-1:0] n_sin;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;

    // widen angle to a full-turn fraction
    assign w_turn = {i_angle, {(TURN_W-ANGLE_WIDTH){1'b0}}};

    // start vector and quarter-turn residue
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_START;
            r_y[0] <= '0;
            r_z[0] <= TRIG_W'(w_turn[TURN_W-3:0]);
            r_q[0] <= w_turn[TURN_W-1 -: 2];
        end
    end

    // micro-rotation stages, floor shifts
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i+1] <= r_q[i];
                if (!r_z[i][TRIG_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - TRIG_W'(ATAN_TURNS[i]);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + TRIG_W'(ATAN_TURNS[i]);
                end
            end
        end
    end

    // fold back into the full circle
    always_comb begin
        case (t_quadrant'(r_q[CORDIC_STAGES]))
            QUAD_I: begin
                n_cos = r_x[CORDIC_STAGES];
                n_sin = r_y[CORDIC_STAGES];
            end
            QUAD_II: begin
                n_cos = -r_y[CORDIC_STAGES];
                n_sin = r_x[CORDIC_STAGES];
            end
            QUAD_III: begin
                n_cos = -r_x[CORDIC_STAGES];
                n_sin = -r_y[CORDIC_STAGES];
            end
            QUAD_IV: begin
                n_cos = r_y[CORDIC_STAGES];
                n_sin = -r_x[CORDIC_STAGES];
            end
            default: begin
                n_cos = '0;
                n_sin = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

/* rtl/f2c_mul.sv */
// ----------------------------------------------------------------------------
// Pipelined Q2.30 scaling multiplier
// Exact product scaled by 2^-30, magnitude rounded half away from zero,
// saturated to the output width. Four register stages.
// ----------------------------------------------------------------------------
module f2c_mul #(
    parameter int A_WIDTH = 32,
    parameter int B_WIDTH = 34,
    parameter int O_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [A_WIDTH-1:0] i_a,
    input  logic signed [B_WIDTH-1:0] i_b,
    output logic signed [O_WIDTH-1:0] o_p
);
    import f2c_pkg::*;

    localparam int AL  = A_WIDTH / 2;
    localparam int AH  = A_WIDTH - AL;
    localparam int PLW = AL + B_WIDTH;
    localparam int PHW = AH + B_WIDTH;
    localparam int PW  = A_WIDTH + B_WIDTH;
    localparam int RW  = PW + 1 - TRIG_FRAC;
    localparam logic [PW:0]   ROUND = (PW+1)'(1) << (TRIG_FRAC - 1);
    localparam logic [RW-1:0] MAXP  = {{(RW-O_WIDTH+1){1'b0}}, {(O_WIDTH-1){1'b1}}};
    localparam logic [RW-1:0] MAXN  = MAXP + RW'(1);

    logic [A_WIDTH-1:0]        r_ma;
    logic [B_WIDTH-1:0]        r_mb;
    logic [PLW-1:0]            r_pl;
    logic [PHW-1:0]            r_ph;
    logic [RW-1:0]             r_mag;
    logic [2:0]                r_neg;
    logic [PW:0]               w_sum;
    logic signed [O_WIDTH-1:0] n_p;
    logic signed [O_WIDTH-1:0] r_p;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma     <= i_a[A_WIDTH-1] ? unsigned'(-i_a) : unsigned'(i_a);
            r_mb     <= i_b[B_WIDTH-1] ? unsigned'(-i_b) : unsigned'(i_b);
            r_neg[0] <= i_a[A_WIDTH-1] ^ i_b[B_WIDTH-1];
        end
    end

    // two partial products over the split first operand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl     <= PLW'(r_ma[AL-1:0]) * PLW'(r_mb);
            r_ph     <= PHW'(r_ma[A_WIDTH-1:AL]) * PHW'(r_mb);
            r_neg[1] <= r_neg[0];
        end
    end

    // recombine, round and drop the fraction
    assign w_sum = (PW+1)'({r_ph, {AL{1'b0}}}) + (PW+1)'(r_pl) + ROUND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= w_sum[PW:TRIG_FRAC];
            r_neg[2] <= r_neg[1];
        end
    end

    // saturate on the magnitude, then apply sign
    always_comb begin
        if (!r_neg[2] && (r_mag > MAXP)) begin
            n_p = {1'b0, {(O_WIDTH-1){1'b1}}};
        end else if (r_neg[2] && (r_mag > MAXN)) begin
            n_p = {1'b1, {(O_WIDTH-1){1'b0}}};
        end else if (r_neg[2]) begin
            n_p = -signed'(O_WIDTH'(r_mag));
        end else begin
            n_p = signed'(O_WIDTH'(r_mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/frame_to_cartesian_converter.sv */
// ----------------------------------------------------------------------------
// Frame to Cartesian converter
// Converts Cartesian, cylindrical or spherical points to Cartesian x, y, z.
// ----------------------------------------------------------------------------
// Takes one point word per clock while input ready is high and returns one
// x/y/z word per point, in order. Kind 0 passes the coordinates through,
// kind 1 (r, azimuth, z) and kind 2 (r, azimuth, polar) are converted with
// CORDIC sine/cosine and rounded, saturating Q2.30 products; kind 3 returns
// zeros. Angles are the low ANGLE_WIDTH bits of their field as a fraction of
// a full turn. The accepting edge loads a point word into the input
// register, then the word passes a CORDIC of CORDIC_STAGES + 2 stages, two
// chained four-stage multipliers and the output register. A skid word behind
// the output register takes one more result while the receiver stalls, after
// which the whole pipeline holds and input ready drops; ready rises again
// with the edge that moves the skid word to the output. With the receiver
// ready the block takes one point per clock.
module frame_to_cartesian_converter #(
    parameter int DATA_WIDTH    = 32,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    f2c_pt_if.sink     i_pt,
    f2c_xyz_if.source  o_xyz
);
    import f2c_pkg::*;

    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int P_IDX      = CORDIC_LAT + MUL_LAT;
    localparam int SB_D       = CORDIC_LAT + 2 * MUL_LAT;

    typedef struct packed {
        t_kind                        kind;
        logic signed [DATA_WIDTH-1:0] a;
        logic signed [DATA_WIDTH-1:0] b;
        logic signed [DATA_WIDTH-1:0] c;
    } t_side;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } t_xyz;

    logic                         en;
    logic [SB_D:0]                r_vld;
    t_side                        n_side;
    t_side                        r_side [0:SB_D];
    logic signed [TRIG_W-1:0]     w_cp;
    logic signed [TRIG_W-1:0]     w_sp;
    logic signed [TRIG_W-1:0]     w_ct;
    logic signed [TRIG_W-1:0]     w_st;
    logic signed [TRIG_W-1:0]     w_p_cs;
    logic signed [TRIG_W-1:0]     w_p_ss;
    logic signed [TRIG_W-1:0]     r_cp_d [0:MUL_LAT-1];
    logic signed [TRIG_W-1:0]     r_sp_d [0:MUL_LAT-1];
    logic signed [TRIG_W-1:0]     r_ct_d [0:MUL_LAT-1];
    logic signed [TRIG_W-1:0]     w_opx;
    logic signed [TRIG_W-1:0]     w_opy;
    logic signed [DATA_WIDTH-1:0] w_rx;
    logic signed [DATA_WIDTH-1:0] w_ry;
    logic signed [DATA_WIDTH-1:0] w_rz;
    t_xyz                         n_res;
    t_xyz                         r_out;
    t_xyz                         r_skid;
    logic                         r_out_vld;
    logic                         r_skid_vld;

    // whole pipeline moves while the skid word is free
    assign en         = !r_skid_vld;
    assign i_pt.ready = en;

    // point word into the sideband line
    always_comb begin
        n_side.kind = i_pt.kind;
        n_side.a    = i_pt.coord_a;
        n_side.b    = i_pt.coord_b;
        n_side.c    = i_pt.coord_c;
    end

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[SB_D-1:0], i_pt.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k <= SB_D; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // azimuth and polar angle trig
    f2c_cordic #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_phi (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (ANGLE_WIDTH'($unsigned(r_side[0].b))),
        .o_cos   (w_cp),
        .o_sin   (w_sp)
    );

    f2c_cordic #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_theta (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (ANGLE_WIDTH'($unsigned(r_side[0].c))),
        .o_cos   (w_ct),
        .o_sin   (w_st)
    );

    // spherical direction products
    f2c_mul #(
        .A_WIDTH (TRIG_W),
        .B_WIDTH (TRIG_W),
        .O_WIDTH (TRIG_W)
    ) u_mul_cs (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (w_cp),
        .i_b   (w_st),
        .o_p   (w_p_cs)
    );

    f2c_mul #(
        .A_WIDTH (TRIG_W),
        .B_WIDTH (TRIG_W),
        .O_WIDTH (TRIG_W)
    ) u_mul_ss (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (w_sp),
        .i_b   (w_st),
        .o_p   (w_p_ss)
    );

    // trig values wait for the direction products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cp_d[0] <= w_cp;
            r_sp_d[0] <= w_sp;
            r_ct_d[0] <= w_ct;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_cp_d[k] <= r_cp_d[k-1];
                r_sp_d[k] <= r_sp_d[k-1];
                r_ct_d[k] <= r_ct_d[k-1];
            end
        end
    end

    // pick the radius scale factors by frame
    always_comb begin
        w_opx = r_cp_d[MUL_LAT-1];
        w_opy = r_sp_d[MUL_LAT-1];
        if (r_side[P_IDX].kind == KIND_SPH) begin
            w_opx = w_p_cs;
            w_opy = w_p_ss;
        end
    end

    // radius scaling with saturation
    f2c_mul #(
        .A_WIDTH (DATA_WIDTH),
        .B_WIDTH (TRIG_W),
        .O_WIDTH (DATA_WIDTH)
    ) u_mul_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_side[P_IDX].a),
        .i_b   (w_opx),
        .o_p   (w_rx)
    );

    f2c_mul #(
        .A_WIDTH (DATA_WIDTH),
        .B_WIDTH (TRIG_W),
        .O_WIDTH (DATA_WIDTH)
    ) u_mul_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_side[P_IDX].a),
        .i_b   (w_opy),
        .o_p   (w_ry)
    );

    f2c_mul #(
        .A_WIDTH (DATA_WIDTH),
        .B_WIDTH (TRIG_W),
        .O_WIDTH (DATA_WIDTH)
    ) u_mul_z (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_side[P_IDX].a),
        .i_b   (r_ct_d[MUL_LAT-1]),
        .o_p   (w_rz)
    );

    // result selection by frame
    always_comb begin
        case (r_side[SB_D].kind)
            KIND_CART: begin
                n_res.x = r_side[SB_D].a;
                n_res.y = r_side[SB_D].b;
                n_res.z = r_side[SB_D].c;
            end
            KIND_CYL: begin
                n_res.x = w_rx;
                n_res.y = w_ry;
                n_res.z = r_side[SB_D].c;
            end
            KIND_SPH: begin
                n_res.x = w_rx;
                n_res.y = w_ry;
                n_res.z = w_rz;
            end
            KIND_INVALID: begin
                n_res = '0;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // output register and skid word control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || o_xyz.ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= en && r_vld[SB_D];
            end
        end else if (en && r_vld[SB_D]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || o_xyz.ready) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else begin
                r_out <= n_res;
            end
        end else if (!r_skid_vld) begin
            r_skid <= n_res;
        end
    end

    assign o_xyz.valid = r_out_vld;
    assign o_xyz.x_out = r_out.x;
    assign o_xyz.y_out = r_out.y;
    assign o_xyz.z_out = r_out.z;

    // pipeline and buffer checks
`include "frame_to_cartesian_converter_macros.svh"

    `F2C_ASSERT_SAME(a_skid_has_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid word without output word")
    `F2C_ASSERT_NEXT(a_skid_kept, i_clk, i_rst_n, r_skid_vld && !o_xyz.ready, r_skid_vld, "skid word dropped")
    `F2C_ASSERT_NEXT(a_last_drained, i_clk, i_rst_n, en && r_vld[SB_D], r_out_vld, "result word lost")
    `F2C_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_pt.valid && i_pt.ready, r_vld[0], "point word lost")

endmodule
